FILE: design/fpst_pkg.sv
package fpst_pkg;

    localparam int POS_W      = 10;
    localparam int DELTA_W    = 32;
    localparam int SUM_W      = 64;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 64;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic [SUM_W-1:0] sum_t;

endpackage

FILE: design/fenwick_prefix_sum_table_core.sv
// Channel | Direction | Signals                          | Contents
// s       | in        | s_tvalid s_tready s_tdata s_tuser | op in tuser; position, delta in tdata
// m       | out       | m_tvalid m_tready m_tdata         | prefix_sum in tdata
//
// An item takes N walk steps: up to log2(TABLE_SIZE) for an add, one per set position bit
// for a query. One node read is issued per cycle during a walk, and a new transfer is only
// taken once the previous item is finished; a position of zero needs no node read.
// After reset a clearing pass writes zero to every node, one per cycle; s_tready stays low
// during that pass.
// A finished query waits in the output register; a stalled m side holds only the next query.
module fenwick_prefix_sum_table_core #(
    parameter int TABLE_SIZE = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [fpst_pkg::S_TDATA_W-1:0] s_tdata,   // position[9:0], delta[41:10], zero pad
    input  logic                           s_tuser,   // op
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fpst_pkg::M_TDATA_W-1:0] m_tdata    // prefix_sum[63:0]
);
    import fpst_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_SIZE);
    localparam int WALK_W = ((IDX_W > POS_W) ? IDX_W : POS_W) + 1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic                 op_reg, op_next;
    logic [DELTA_W-1:0]   delta_reg, delta_next;
    logic [WALK_W-1:0]    idx_reg, idx_next;
    logic                 pend_reg, pend_next;
    logic [IDX_W-1:0]     pend_addr_reg, pend_addr_next;
    sum_t                 acc_reg, acc_next;
    logic                 out_valid_reg, out_valid_next;
    sum_t                 out_data_reg, out_data_next;

    sum_t                 mem [TABLE_SIZE];
    sum_t                 rd_data_reg;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    sum_t                 wr_data;

    logic                 in_rng;
    logic [WALK_W-1:0]    low_bit;

    assign in_rng  = (idx_reg != '0) && (idx_reg < WALK_W'(TABLE_SIZE));
    assign low_bit = idx_reg & (~idx_reg + WALK_W'(1));

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        op_next        = op_reg;
        delta_next     = delta_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = pend_addr_reg;
        wr_data        = rd_data_reg + {{(SUM_W-DELTA_W){delta_reg[DELTA_W-1]}}, delta_reg};

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = '0;
                clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                if (clr_cnt_reg == IDX_W'(TABLE_SIZE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = s_tuser;
                    idx_next   = WALK_W'(s_tdata[POS_W-1:0]);
                    delta_next = s_tdata[POS_W+DELTA_W-1:POS_W];
                    acc_next   = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                // The node read in the previous cycle is folded in now; the next
                // read always targets a different node, so no forwarding is needed.
                if (pend_reg && (op_reg == OP_ADD))
                begin
                    wr_en = 1'b1;
                end
                if (pend_reg && (op_reg == OP_QUERY))
                begin
                    acc_next = acc_reg + rd_data_reg;
                end
                if (op_reg == OP_ADD)
                begin
                    if (in_rng)
                    begin
                        rd_en          = 1'b1;
                        pend_next      = 1'b1;
                        pend_addr_next = idx_reg[IDX_W-1:0];
                        idx_next       = idx_reg + low_bit;
                    end
                    else if (!pend_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    if (idx_reg != '0)
                    begin
                        rd_en     = in_rng;
                        pend_next = in_rng;
                        idx_next  = idx_reg & (idx_reg - WALK_W'(1));
                    end
                    else if (!pend_reg)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            op_reg        <= OP_ADD;
            delta_reg     <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_addr_reg <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            op_reg        <= op_next;
            delta_reg     <= delta_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            pend_addr_reg <= pend_addr_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_no_rw_same_node: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write hit the same node in one cycle");

    a_pend_only_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_WALK))
        else $error("pending node read outside of a walk");

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("input ready during clearing pass");

    a_query_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && (state_next == ST_IDLE)) |=> m_tvalid)
        else $error("finished query did not reach the output register");

endmodule
